>>> rtl/mce_pkg.sv
// Shared types and constants for the Morse code encoder.
// Holds the symbol codes, the job record passed from classifier to emitter,
// and the letter/digit code lookup. No dependencies.
`timescale 1ns / 1ps

package mce_pkg;

  localparam int MAX_SYMS = 6;   // one gap plus up to five dots/dashes
  localparam int SYM_W    = 3;
  localparam int CNT_W    = 3;
  localparam int IDX_W    = 6;   // 36 table entries

  typedef enum logic [SYM_W-1:0] {
    SYM_DOT        = 3'd0,
    SYM_DASH       = 3'd1,
    SYM_LETTER_GAP = 3'd2,
    SYM_WORD_GAP   = 3'd3,
    SYM_LINE_END   = 3'd4
  } sym_t;

  // Work for one accepted item: symbols in order, syms[0] goes out first.
  typedef struct packed {
    logic                              valid;
    logic [CNT_W-1:0]                  count;
    logic                              line_error;
    logic [MAX_SYMS-1:0][SYM_W-1:0]    syms;
  } job_t;

  // Entry layout: {length[2:0], pattern[4:0]}, pattern bit 0 is the first
  // element, 1 = dash. Entries 0..25 are A..Z, 26..35 are 0..9.
  function automatic logic [7:0] code_lookup(input logic [IDX_W-1:0] idx);
    logic [7:0] entry;
    case (idx)
      6'd0:  entry = {3'd2, 5'b00010};
      6'd1:  entry = {3'd4, 5'b00001};
      6'd2:  entry = {3'd4, 5'b00101};
      6'd3:  entry = {3'd3, 5'b00001};
      6'd4:  entry = {3'd1, 5'b00000};
      6'd5:  entry = {3'd4, 5'b00100};
      6'd6:  entry = {3'd3, 5'b00011};
      6'd7:  entry = {3'd4, 5'b00000};
      6'd8:  entry = {3'd2, 5'b00000};
      6'd9:  entry = {3'd4, 5'b01110};
      6'd10: entry = {3'd3, 5'b00101};
      6'd11: entry = {3'd4, 5'b00010};
      6'd12: entry = {3'd2, 5'b00011};
      6'd13: entry = {3'd2, 5'b00001};
      6'd14: entry = {3'd3, 5'b00111};
      6'd15: entry = {3'd4, 5'b00110};
      6'd16: entry = {3'd4, 5'b01011};
      6'd17: entry = {3'd3, 5'b00010};
      6'd18: entry = {3'd3, 5'b00000};
      6'd19: entry = {3'd1, 5'b00001};
      6'd20: entry = {3'd3, 5'b00100};
      6'd21: entry = {3'd4, 5'b01000};
      6'd22: entry = {3'd3, 5'b00110};
      6'd23: entry = {3'd4, 5'b01001};
      6'd24: entry = {3'd4, 5'b01101};
      6'd25: entry = {3'd4, 5'b00011};
      6'd26: entry = {3'd5, 5'b11111};
      6'd27: entry = {3'd5, 5'b11110};
      6'd28: entry = {3'd5, 5'b11100};
      6'd29: entry = {3'd5, 5'b11000};
      6'd30: entry = {3'd5, 5'b10000};
      6'd31: entry = {3'd5, 5'b00000};
      6'd32: entry = {3'd5, 5'b00001};
      6'd33: entry = {3'd5, 5'b00011};
      6'd34: entry = {3'd5, 5'b00111};
      6'd35: entry = {3'd5, 5'b01111};
      default: entry = 8'd0;
    endcase
    return entry;
  endfunction

endpackage

>>> rtl/mce_classify.sv
// Character classifier and word-state registers for the Morse encoder.
// Turns one input item into a symbol job and updates the line state.
// Depends on mce_pkg.
`timescale 1ns / 1ps

module mce_classify (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 op,
  input  logic [7:0]           char_code,
  output mce_pkg::job_t        job
);

  localparam logic [7:0] CH_SPACE = 8'h20;

  logic inside_word;
  logic nothing_emitted_yet;
  logic error_seen;
  logic inside_word_next;
  logic nothing_emitted_yet_next;
  logic error_seen_next;

  logic                         is_upper;
  logic                         is_lower;
  logic                         is_digit;
  logic                         is_space;
  logic                         is_skip;
  logic [mce_pkg::IDX_W-1:0]    idx;
  logic [7:0]                   entry;
  logic                         gap;
  logic [mce_pkg::MAX_SYMS-1:0] pat_sh;

  assign is_upper = (char_code >= 8'h41) && (char_code <= 8'h5A);
  assign is_lower = (char_code >= 8'h61) && (char_code <= 8'h7A);
  assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign is_space = (char_code == CH_SPACE);
  assign is_skip  = (char_code == 8'h2C) || (char_code == 8'h2E) || (char_code == 8'h3B) ||
                    (char_code == 8'h3A) || (char_code == 8'h2D) || (char_code == 8'h21) ||
                    (char_code == 8'h3F) || (char_code == 8'h27) || (char_code == 8'h22);

  always_comb begin
    priority if (is_upper) begin
      idx = 6'(char_code - 8'h41);
    end else if (is_lower) begin
      idx = 6'(char_code - 8'h61);
    end else begin
      idx = 6'(char_code - 8'h30 + 8'd26);
    end
  end

  assign entry  = mce_pkg::code_lookup(idx);
  assign gap    = !nothing_emitted_yet;
  // make room for the gap symbol in front of the pattern
  assign pat_sh = gap ? {entry[4:0], 1'b0} : {1'b0, entry[4:0]};

  always_comb begin
    job            = '0;
    inside_word_next         = inside_word;
    nothing_emitted_yet_next = nothing_emitted_yet;
    error_seen_next          = error_seen;
    for (int i = 0; i < mce_pkg::MAX_SYMS; i++) begin
      job.syms[i] = pat_sh[i] ? mce_pkg::SYM_DASH : mce_pkg::SYM_DOT;
    end
    if (gap) begin
      job.syms[0] = inside_word ? mce_pkg::SYM_LETTER_GAP : mce_pkg::SYM_WORD_GAP;
    end
    job.count = entry[7:5] + {2'b00, gap};

    priority if (op) begin
      job.valid      = 1'b1;
      job.count      = 3'd1;
      job.line_error = error_seen;
      job.syms[0]    = mce_pkg::SYM_LINE_END;
      inside_word_next         = 1'b0;
      nothing_emitted_yet_next = 1'b1;
      error_seen_next          = 1'b0;
    end else if (error_seen) begin
      job.valid = 1'b0;
    end else if (is_space) begin
      job.valid        = 1'b0;
      inside_word_next = 1'b0;
    end else if (is_skip) begin
      job.valid = 1'b0;
    end else if (is_upper || is_lower || is_digit) begin
      job.valid                = 1'b1;
      inside_word_next         = 1'b1;
      nothing_emitted_yet_next = 1'b0;
    end else begin
      // invalid character: drop the rest of the line until its end
      job.valid       = 1'b0;
      error_seen_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word         <= 1'b0;
      nothing_emitted_yet <= 1'b1;
      error_seen          <= 1'b0;
    end else if (fire) begin
      inside_word         <= inside_word_next;
      nothing_emitted_yet <= nothing_emitted_yet_next;
      error_seen          <= error_seen_next;
    end
  end

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    fire && op |=> nothing_emitted_yet && !inside_word && !error_seen)
    else $error("line end did not clear word state");

  a_word_needs_letter: assert property (@(posedge clk) disable iff (rst)
    inside_word |-> !nothing_emitted_yet)
    else $error("inside a word with no letter emitted");

  a_error_freezes: assert property (@(posedge clk) disable iff (rst)
    fire && !op && error_seen |=> error_seen && $stable(inside_word)
      && $stable(nothing_emitted_yet))
    else $error("state changed after an invalid character");

endmodule

>>> rtl/mce_emit.sv
// Result register and symbol sequencer for the Morse encoder.
// Holds one symbol job and hands its symbols out one per accepted result.
// Depends on mce_pkg.
`timescale 1ns / 1ps

module mce_emit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  mce_pkg::job_t        job,
  output logic                 take_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           symbol,
  output logic                 line_error,
  output logic                 last
);

  logic                                           busy;
  logic [mce_pkg::CNT_W-1:0]                      count;
  logic                                           err;
  logic [mce_pkg::MAX_SYMS-1:0][mce_pkg::SYM_W-1:0] syms;
  logic                                           out_fire;

  assign out_valid  = busy;
  assign symbol     = syms[0];
  assign line_error = err;
  assign last       = (count == 3'd1);
  assign out_fire   = busy && out_ready;
  // take a new job when empty or as the final symbol leaves
  assign take_ok    = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (out_fire && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      count <= job.count;
      err   <= job.line_error;
      syms  <= job.syms;
    end else if (out_fire) begin
      count <= count - 3'd1;
      syms  <= {mce_pkg::SYM_W'(mce_pkg::SYM_DOT), syms[mce_pkg::MAX_SYMS-1:1]};
    end
  end

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> (count != 3'd0) && (count <= 3'(mce_pkg::MAX_SYMS)))
    else $error("job count out of range while busy");

  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    busy && symbol == mce_pkg::SYM_LINE_END |-> last)
    else $error("line end item is not the last result");

  a_error_on_line_end: assert property (@(posedge clk) disable iff (rst)
    busy && line_error |-> symbol == mce_pkg::SYM_LINE_END)
    else $error("error flag on a symbol that is not a line end");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    out_fire && !last && !load |=> busy && count == $past(count) - 3'd1)
    else $error("sequencer did not advance");

endmodule

>>> rtl/morse_code_encoder_unit.sv
// Top level of the streaming Morse code encoder.
// Instantiates the classifier (mce_classify) and the sequencer (mce_emit).
// Depends on mce_pkg.
`timescale 1ns / 1ps

// Accepts one character or end-of-line item per cycle while the result side
// keeps up and the result register holds at most its final result. A letter
// or digit is decoded in the cycle it is accepted and gives one to six results
// (an optional letter or word gap, then its dots and dashes), sent one per
// cycle from the result register while out_ready is high; the next item is
// taken in the same cycle as the previous item's last result. Spaces, skipped
// punctuation, invalid characters and characters after an invalid one give no
// results. An end-of-line item gives a single line-end result whose line_error
// flag tells the consumer to discard the line.

module morse_code_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  symbol,
  output logic        line_error,
  output logic        last
);

  mce_pkg::job_t job;
  logic          in_fire;

  assign in_fire = in_valid && in_ready;

  mce_classify u_classify (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .op        (op),
    .char_code (char_code),
    .job       (job)
  );

  mce_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (in_fire && job.valid),
    .job        (job),
    .take_ok    (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .symbol     (symbol),
    .line_error (line_error),
    .last       (last)
  );

endmodule
